[hdl/pimw_pkg.sv]
// Shared types and constants for the pair invariant mass window block.
package pimw_pkg;

	localparam int DEF_MAX_PER_ROLE = 16;
	localparam int DRAIN_CYC        = 6;

	localparam int E_W    = 16;
	localparam int WORD_W = 64;
	localparam int MIN_W  = 13;
	localparam int MAX_W  = 14;
	localparam int CFG_W  = 14;
	localparam int M2_W   = 36;
	localparam int BND_W  = 32;

	localparam logic [1:0] KIND_ELEC = 2'd0;
	localparam logic [1:0] KIND_MUON = 2'd1;
	localparam logic [1:0] KIND_TAU  = 2'd2;

	localparam logic [1:0] MODE_E_MU    = 2'd0;
	localparam logic [1:0] MODE_E_TAU   = 2'd1;
	localparam logic [1:0] MODE_MU_TAU  = 2'd2;
	localparam logic [1:0] MODE_TAU_TAU = 2'd3;

	localparam logic [1:0] REG_PAIR_MODE = 2'd0;
	localparam logic [1:0] REG_MASS_MIN  = 2'd1;
	localparam logic [1:0] REG_MASS_MAX  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rotate;
		logic load;
	} ring_ctl_t;

	typedef struct packed {
		logic valid;
		logic pass;
	} mass_res_t;

endpackage

[hdl/pair_invariant_mass_window.sv]
// Top level of the pair invariant mass window event selector.
//
// Usage:
//   Particles of one event arrive as words on the s_ channel: kind on tuser,
//   {pz, py, px, E} on tdata, tlast on the final particle of the event.
//   Each particle is paired with every stored partner of the configured
//   pairing; its squared pair mass is tested against the squared window.
//   On the last particle one word leaves on the m_ channel with the pass and
//   overflow flags; other particles produce no output.
//   Once a particle is accepted, s_tready stays low while the partner ring
//   rotates once through the single shared mass pipeline (one pair per cycle),
//   the pipeline drains and the particle is stored. The result word appears
//   in the same cycle that s_tready returns.
//   The output word sits in a register; the next event is accepted while it
//   waits. If m_tready stays low, the last particle of the following event
//   holds in its final state until the output register frees up.
//   Reset clears counts, flags and configuration (pair mode 0, min 0,
//   max unbounded). Configuration is written through cfg_wen/cfg_index/
//   cfg_data while no particle is in flight.
module pair_invariant_mass_window
	import pimw_pkg::*;
#(
	parameter int MAX_PER_ROLE = DEF_MAX_PER_ROLE
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,   // energy, mom_x, mom_y, mom_z
	input  logic             s_tlast,   // is_last
	input  logic [1:0]       s_tuser,   // kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // selected, overflowed, zero fill
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IDX_W  = (MAX_PER_ROLE > 1) ? $clog2(MAX_PER_ROLE) : 1;
	localparam int CNT_W  = $clog2(MAX_PER_ROLE + 1);
	localparam int STEP_W = $clog2(MAX_PER_ROLE + DRAIN_CYC + 1);

	state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	logic [1:0]              pair_mode_q;
	logic [MIN_W-1:0]        mass_min_q;
	logic signed [MAX_W-1:0] mass_max_q;

	logic [WORD_W-1:0] p_q;
	logic              last_q;
	logic              has_role_q;
	logic              partner_first_q;
	logic              store_first_q;

	logic [CNT_W-1:0] cnt1_q, cnt2_q;
	logic             pass_q, ovf_q;
	logic             m_tvalid_q, sel_q, ovf_out_q;

	logic [1:0] first_kind, second_kind;
	logic       role_d, partner_first_d, store_first_d;
	logic       scan_en, done_go, accept;
	logic       full1, full2, store_full;
	logic [CNT_W-1:0] partner_cnt, store_cnt;
	ring_ctl_t  ctl1, ctl2;
	logic [WORD_W-1:0] head1, head2;
	mass_res_t  hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_mode_q <= MODE_E_MU;
			mass_min_q  <= '0;
			mass_max_q  <= '1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_PAIR_MODE: pair_mode_q <= cfg_data[1:0];
				REG_MASS_MIN:  mass_min_q  <= cfg_data[MIN_W-1:0];
				REG_MASS_MAX:  mass_max_q  <= cfg_data[MAX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (pair_mode_q)
			MODE_E_MU:   begin first_kind = KIND_ELEC; second_kind = KIND_MUON; end
			MODE_E_TAU:  begin first_kind = KIND_ELEC; second_kind = KIND_TAU;  end
			MODE_MU_TAU: begin first_kind = KIND_MUON; second_kind = KIND_TAU;  end
			default:     begin first_kind = KIND_TAU;  second_kind = KIND_TAU;  end
		endcase
		role_d          = 1'b0;
		partner_first_d = 1'b1;
		store_first_d   = 1'b1;
		if (pair_mode_q == MODE_TAU_TAU) begin
			role_d = (s_tuser == KIND_TAU);
		end else if (s_tuser == first_kind) begin
			role_d          = 1'b1;
			partner_first_d = 1'b0;
		end else if (s_tuser == second_kind) begin
			role_d        = 1'b1;
			store_first_d = 1'b0;
		end
	end

	assign full1       = (cnt1_q == CNT_W'(MAX_PER_ROLE));
	assign full2       = (cnt2_q == CNT_W'(MAX_PER_ROLE));
	assign partner_cnt = partner_first_q ? cnt1_q : cnt2_q;
	assign store_cnt   = store_first_q ? cnt1_q : cnt2_q;
	assign store_full  = store_first_q ? full1 : full2;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_SCAN;
			ST_SCAN:  if (step_q == STEP_W'(MAX_PER_ROLE - 1)) state_d = ST_DRAIN;
			ST_DRAIN: if (step_q == STEP_W'(DRAIN_CYC - 1)) state_d = ST_DONE;
			ST_DONE:  if (done_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		scan_en  = (state_q == ST_SCAN);
		done_go  = (state_q == ST_DONE) && (!last_q || !m_tvalid_q || m_tready);
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q             <= s_tdata;
			last_q          <= s_tlast;
			has_role_q      <= role_d;
			partner_first_q <= partner_first_d;
			store_first_q   <= store_first_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt1_q <= '0;
			cnt2_q <= '0;
			pass_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			if (hit.valid && hit.pass) begin
				pass_q <= 1'b1;
			end
			if (done_go) begin
				if (last_q) begin
					cnt1_q <= '0;
					cnt2_q <= '0;
					pass_q <= 1'b0;
					ovf_q  <= 1'b0;
				end else if (has_role_q) begin
					if (store_full) begin
						ovf_q <= 1'b1;
					end else if (store_first_q) begin
						cnt1_q <= cnt1_q + CNT_W'(1);
					end else begin
						cnt2_q <= cnt2_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			sel_q      <= 1'b0;
			ovf_out_q  <= 1'b0;
		end else if (done_go && last_q) begin
			m_tvalid_q <= 1'b1;
			sel_q      <= pass_q;
			ovf_out_q  <= ovf_q || (has_role_q && store_full);
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, ovf_out_q, sel_q};

	always_comb begin
		ctl1.rotate = scan_en && partner_first_q;
		ctl2.rotate = scan_en && !partner_first_q;
		ctl1.load   = done_go && !last_q && has_role_q && store_first_q && !full1;
		ctl2.load   = done_go && !last_q && has_role_q && !store_first_q && !full2;
	end

	pimw_ring #(.DEPTH(MAX_PER_ROLE)) u_ring1 (
		.clk     (clk),
		.ctl     (ctl1),
		.wr_idx  (store_cnt[IDX_W-1:0]),
		.wr_data (p_q),
		.head    (head1)
	);

	pimw_ring #(.DEPTH(MAX_PER_ROLE)) u_ring2 (
		.clk     (clk),
		.ctl     (ctl2),
		.wr_idx  (store_cnt[IDX_W-1:0]),
		.wr_data (p_q),
		.head    (head2)
	);

	pimw_mass u_mass (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (scan_en && has_role_q && (step_q < STEP_W'(partner_cnt))),
		.a        (p_q),
		.b        (partner_first_q ? head1 : head2),
		.mass_min (mass_min_q),
		.mass_max (mass_max_q),
		.res      (hit)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt1_q <= CNT_W'(MAX_PER_ROLE)) && (cnt2_q <= CNT_W'(MAX_PER_ROLE)))
		else $error("role count beyond capacity");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE && last_q))
		else $error("result word not caused by a last particle");

	a_hit_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("pair result outside scan window");

	a_store_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl1.load || ctl2.load) |-> !(ctl1.rotate || ctl2.rotate))
		else $error("ring written while rotating");

endmodule

[hdl/pimw_cell.sv]
// One storage cell of a particle ring: loads a new word or takes its neighbor's.
module pimw_cell
	import pimw_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic              shift,
	input  logic [WORD_W-1:0] din,
	input  logic [WORD_W-1:0] nbr,
	output logic [WORD_W-1:0] q
);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end else if (shift) begin
			data_q <= nbr;
		end
	end

	assign q = data_q;

endmodule

[hdl/pimw_ring.sv]
// Ring of particle cells; a full rotation presents every cell at the head once.
module pimw_ring
	import pimw_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_PER_ROLE,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  ring_ctl_t         ctl,
	input  logic [IDX_W-1:0]  wr_idx,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] head
);

	logic [WORD_W-1:0] cell_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		pimw_cell u_cell (
			.clk   (clk),
			.load  (ctl.load && (wr_idx == IDX_W'(i))),
			.shift (ctl.rotate),
			.din   (wr_data),
			.nbr   (cell_q[(i + 1) % DEPTH]),
			.q     (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule

[hdl/pimw_mass.sv]
// Pipelined squared invariant mass of a particle pair and window test.
module pimw_mass
	import pimw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	input  logic [WORD_W-1:0]       a,
	input  logic [WORD_W-1:0]       b,
	input  logic [MIN_W-1:0]        mass_min,
	input  logic signed [MAX_W-1:0] mass_max,
	output mass_res_t               res
);

	logic [MIN_W*2-1:0] min_sq;
	logic [MIN_W*2-1:0] max_sq;
	logic [BND_W-1:0]   lo_q;
	logic [BND_W-1:0]   hi_q;
	logic               unb_q;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [E_W:0]         e_s1;
	logic signed [E_W:0]  x_s1, y_s1, z_s1;
	logic [2*E_W+1:0]     e2_s2;
	logic [2*E_W:0]       x2_s2, y2_s2, z2_s2;
	logic signed [2*E_W+1:0] xp, yp, zp;
	logic signed [M2_W-1:0] d_s3;
	logic [2*E_W+1:0]     yz_s3;
	logic signed [M2_W-1:0] m2_s4;
	logic                 pass_s5;

	assign min_sq = (MIN_W*2)'(mass_min) * (MIN_W*2)'(mass_min);
	assign max_sq = (MIN_W*2)'(mass_max[MIN_W-1:0]) * (MIN_W*2)'(mass_max[MIN_W-1:0]);

	always_ff @(posedge clk) begin
		lo_q  <= {min_sq, 6'b0};
		hi_q  <= {max_sq, 6'b0};
		unb_q <= mass_max[MAX_W-1];
	end

	assign xp = (2*E_W+2)'(x_s1) * (2*E_W+2)'(x_s1);
	assign yp = (2*E_W+2)'(y_s1) * (2*E_W+2)'(y_s1);
	assign zp = (2*E_W+2)'(z_s1) * (2*E_W+2)'(z_s1);

	always_ff @(posedge clk) begin
		e_s1  <= {1'b0, a[15:0]} + {1'b0, b[15:0]};
		x_s1  <= {a[31], a[31:16]} + {b[31], b[31:16]};
		y_s1  <= {a[47], a[47:32]} + {b[47], b[47:32]};
		z_s1  <= {a[63], a[63:48]} + {b[63], b[63:48]};
		e2_s2 <= (2*E_W+2)'(e_s1) * (2*E_W+2)'(e_s1);
		x2_s2 <= xp[2*E_W:0];
		y2_s2 <= yp[2*E_W:0];
		z2_s2 <= zp[2*E_W:0];
		d_s3  <= $signed(M2_W'(e2_s2)) - $signed(M2_W'(x2_s2));
		yz_s3 <= (2*E_W+2)'(y2_s2) + (2*E_W+2)'(z2_s2);
		m2_s4 <= d_s3 - $signed(M2_W'(yz_s3));
		pass_s5 <= (m2_s4 >= $signed(M2_W'(lo_q))) && !m2_s4[M2_W-1] &&
			(unb_q || (m2_s4 <= $signed(M2_W'(hi_q))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign res.valid = v_s5;
	assign res.pass  = pass_s5;

endmodule
